/* design/ddlm_pkg.sv */
// Shared types and constants for the discount DLM forward filter.
// No dependencies.
package ddlm_pkg;

  localparam int MAX_ORDER_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATE_DISC = 2'd0,
    CFG_VAR_DISC   = 2'd1,
    CFG_ORDER      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] regressor;
    logic signed [31:0] observation;
    logic               series_start;
  } in_word_t;

  typedef struct packed {
    logic        [2:0]  component_index;
    logic signed [31:0] component_mean;
    logic signed [31:0] forecast;
    logic        [30:0] forecast_variance;
    logic        [30:0] scale_estimate;
    logic        [30:0] degrees_freedom;
    logic               numeric_error;
    logic               last_component;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/discount_dlm_forward_filter.sv */
// Top level: discount DLM forward filter sequencer, state RAMs and shared arithmetic.
// Depends on ddlm_pkg, ddlm_ram and ddlm_div.
//
//   port group   dir  handshake               word
//   in_*         in   in_valid_i/in_stall_o   in_word_t: regressor, observation, series_start
//   out_*        out  out_valid_o/out_stall_i out_word_t: one word per state component
//   cfg_*        in   cfg_valid_i/cfg_ready_o register index, write data
//
// A row element that does not close the row is taken while the sequencer stays idle. The closing
// element runs the whole step through one shared multiplier and one divider; the two covariance
// passes each do one divide per entry.
// A failed step skips the update passes; stalls in the output pass lengthen the step.
// Input is stalled while a step runs; the result register lets the next word in while the last output waits.
// Reset restores zero mean, identity covariance and unit n, d, S (valid bits).
module discount_dlm_forward_filter import ddlm_pkg::*; #(
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DW   = DATA_WIDTH;
  localparam int IW   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW   = $clog2(MAX_ORDER + 1);
  localparam int CD   = MAX_ORDER * MAX_ORDER;
  localparam int CA_W = (CD > 1) ? $clog2(CD) : 1;
  localparam int SW   = (DATA_WIDTH + 6 > 34) ? DATA_WIDTH + 6 : 34;
  localparam int MW   = (DATA_WIDTH > 17) ? DATA_WIDTH : 17;

  localparam logic signed [SW-1:0] VMAX_S = (SW'(1) << (DATA_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;
  localparam logic signed [SW-1:0] ONE_S  = SW'(65536);
  localparam logic signed [SW-1:0] O32MAX = SW'(32'h7FFF_FFFF);
  localparam logic signed [SW-1:0] O32MIN = ~O32MAX;
  localparam logic [2*MW-1:0] VMAX_P = ((2*MW)'(1) << (DATA_WIDTH - 1)) - (2*MW)'(1);
  localparam logic signed [DW-1:0] ONE_DW =
    (DATA_WIDTH > 17) ? ONE_S[DW-1:0] : VMAX_S[DW-1:0];

  typedef enum logic [27:0] {
    S_IDLE    = 28'd1 << 0,  S_F_RD    = 28'd1 << 1,  S_F_MUL  = 28'd1 << 2,
    S_F_ACC   = 28'd1 << 3,  S_A_RD    = 28'd1 << 4,  S_A_DIV  = 28'd1 << 5,
    S_A_MUL   = 28'd1 << 6,  S_A_ACC   = 28'd1 << 7,  S_Q_MUL  = 28'd1 << 8,
    S_Q_ACC   = 28'd1 << 9,  S_K_DIV   = 28'd1 << 10, S_E_SET  = 28'd1 << 11,
    S_N_SET   = 28'd1 << 12, S_SEE_MUL = 28'd1 << 13, S_SEE_DIV = 28'd1 << 14,
    S_D_MUL   = 28'd1 << 15, S_D_SET   = 28'd1 << 16, S_S_DIV  = 28'd1 << 17,
    S_R_DIV   = 28'd1 << 18, S_C_RD    = 28'd1 << 19, S_C_DIV  = 28'd1 << 20,
    S_C_MUL   = 28'd1 << 21, S_C_SUB   = 28'd1 << 22, S_C_MUL2 = 28'd1 << 23,
    S_C_WR    = 28'd1 << 24, S_O_RD    = 28'd1 << 25, S_O_MUL  = 28'd1 << 26,
    S_O_LD    = 28'd1 << 27
  } state_e;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
    if (v > VMAX_S) return VMAX_S[DW-1:0];
    if (v < VMIN_S) return VMIN_S[DW-1:0];
    return v[DW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] to_sw(input logic signed [DW-1:0] v);
    return SW'(v);
  endfunction

  function automatic logic signed [MW-1:0] to_mw(input logic signed [DW-1:0] v);
    return MW'(v);
  endfunction

  function automatic logic signed [DW-1:0] qmul(input logic signed [MW-1:0] a,
                                                input logic signed [MW-1:0] b);
    logic            neg;
    logic [MW-1:0]   ma, mb;
    logic [2*MW-1:0] p, r;
    logic [DW-1:0]   res;
    neg = a[MW-1] ^ b[MW-1];
    ma  = a[MW-1] ? MW'(-a) : MW'(a);
    mb  = b[MW-1] ? MW'(-b) : MW'(b);
    p   = (2*MW)'(ma) * (2*MW)'(mb);
    r   = (p + (2*MW)'(32768)) >> FRAC_BITS;
    res = r[DW-1:0];
    if (neg) begin
      if (r > VMAX_P + (2*MW)'(1)) return VMIN_S[DW-1:0];
      return -res;
    end
    if (r > VMAX_P) return VMAX_S[DW-1:0];
    return res;
  endfunction

  function automatic logic signed [31:0] out_s32(input logic signed [DW-1:0] v);
    logic signed [SW-1:0] x;
    x = SW'(v);
    if (x > O32MAX) return O32MAX[31:0];
    if (x < O32MIN) return O32MIN[31:0];
    return x[31:0];
  endfunction

  function automatic logic [30:0] out_u31(input logic signed [DW-1:0] v);
    logic signed [SW-1:0] x;
    x = SW'(v);
    if (x < 0) return '0;
    if (x > O32MAX) return 31'h7FFF_FFFF;
    return x[30:0];
  endfunction

  state_e state_q;
  logic [CW-1:0] i_q, j_q, ord, i_nx, j_nx;
  logic          i_last, j_last;
  logic [IW-1:0] ec_q, ec_eff, sel;
  logic [4:0]    ord_raw;
  logic [16:0]   delta_q, delta_eff;
  logic [15:0]   beta_q;
  logic [3:0]    order_q;

  logic signed [SW-1:0] acc_q, acc_nx;
  logic signed [DW-1:0] f_q, q_q, e_q, y_q, nn_q, dn_q, sn_q, ratio_q, t_q, mul_q;
  logic signed [DW-1:0] n_q, d_q, s_q, q_new;
  logic signed [DW-1:0] row_q [MAX_ORDER];
  logic signed [DW-1:0] av_q  [MAX_ORDER];
  logic signed [DW-1:0] kv_q  [MAX_ORDER];
  logic [CD-1:0]        cvalid_q;
  logic [MAX_ORDER-1:0] mvalid_q;
  logic                 cvld_q, cdiag_q, mvld_q, err_q, div_wait_q;

  logic                 in_acc, slot_free, row_done, out_load;
  logic                 out_valid_q;
  out_word_t            out_q;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [DW-1:0] mul_res;
  logic                 div_start;
  logic signed [DW-1:0] div_num, div_res;
  logic signed [SW-1:0] div_den;
  div_stat_t            div_stat;

  logic                 cov_re, cov_we, mean_re, mean_we;
  logic [CA_W-1:0]      cov_addr;
  logic [DW-1:0]        cov_rdata, mean_rdata;
  logic signed [DW-1:0] cov_rd, mean_rd, mean_new;
  logic                 div_state;

  assign ord_raw   = {1'b0, order_q};
  assign ord       = (order_q == '0) ? CW'(1) :
                     (ord_raw > 5'(MAX_ORDER)) ? CW'(MAX_ORDER) : CW'(ord_raw);
  assign i_nx      = i_q + CW'(1);
  assign j_nx      = j_q + CW'(1);
  assign i_last    = (i_nx == ord);
  assign j_last    = (j_nx == ord);
  assign delta_eff = (delta_q == '0) ? 17'd1 : delta_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign ec_eff    = in_word_i.series_start ? '0 : ec_q;
  assign row_done  = !(CW'(ec_eff) + CW'(1) < ord);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == S_O_LD) && slot_free;
  assign acc_nx    = acc_q + to_sw(mul_q);
  assign q_new     = sat_dw(acc_nx);
  assign sel       = (state_q == S_A_MUL || state_q == S_C_MUL) ? j_q[IW-1:0] : i_q[IW-1:0];
  assign cov_addr  = CA_W'(i_q * MAX_ORDER + j_q);
  assign cov_rd    = cvld_q ? cov_rdata : (cdiag_q ? ONE_DW : '0);
  assign mean_rd   = mvld_q ? mean_rdata : '0;
  assign mean_new  = sat_dw(to_sw(mean_rd) + to_sw(mul_q));
  assign div_state = (state_q == S_A_DIV) || (state_q == S_C_DIV) || (state_q == S_K_DIV) ||
                     (state_q == S_SEE_DIV) || (state_q == S_S_DIV) || (state_q == S_R_DIV);
  assign div_start = div_state && !div_wait_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_F_MUL:   begin mul_a = to_mw(row_q[sel]); mul_b = to_mw(mean_rd); end
      S_A_MUL:   begin mul_a = to_mw(div_res);    mul_b = to_mw(row_q[sel]); end
      S_Q_MUL:   begin mul_a = to_mw(row_q[sel]); mul_b = to_mw(av_q[sel]); end
      S_E_SET:   begin mul_a = to_mw(n_q);        mul_b = MW'(beta_q); end
      S_N_SET:   begin mul_a = to_mw(s_q);        mul_b = to_mw(e_q); end
      S_SEE_MUL: begin mul_a = to_mw(mul_q);      mul_b = to_mw(e_q); end
      S_D_MUL:   begin mul_a = MW'(beta_q);       mul_b = to_mw(d_q); end
      S_C_MUL:   begin mul_a = to_mw(kv_q[i_q[IW-1:0]]); mul_b = to_mw(av_q[sel]); end
      S_C_MUL2:  begin mul_a = to_mw(ratio_q);    mul_b = to_mw(t_q); end
      S_O_MUL:   begin mul_a = to_mw(kv_q[i_q[IW-1:0]]); mul_b = to_mw(e_q); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_res = qmul(mul_a, mul_b);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_q)
      S_A_DIV, S_C_DIV: begin div_num = cov_rd;  div_den = SW'(delta_eff); end
      S_K_DIV:   begin div_num = av_q[i_q[IW-1:0]]; div_den = to_sw(q_q); end
      S_SEE_DIV: begin div_num = mul_q; div_den = to_sw(q_q); end
      S_S_DIV:   begin div_num = dn_q;  div_den = to_sw(nn_q); end
      S_R_DIV:   begin div_num = sn_q;  div_den = to_sw(s_q); end
      default:   begin div_num = '0;    div_den = '0; end
    endcase
  end

  assign cov_re  = (state_q == S_A_RD) || (state_q == S_C_RD);
  assign cov_we  = (state_q == S_C_WR);
  assign mean_re = (state_q == S_F_RD) || (state_q == S_O_RD);
  assign mean_we = (state_q == S_O_LD) && slot_free && !err_q;

  ddlm_ram #(.WIDTH(DW), .DEPTH(CD)) u_cov_ram (
    .clk_i   (clk_i),
    .we_i    (cov_we),
    .waddr_i (cov_addr),
    .wdata_i (mul_q),
    .re_i    (cov_re),
    .raddr_i (cov_addr),
    .rdata_o (cov_rdata)
  );

  ddlm_ram #(.WIDTH(DW), .DEPTH(MAX_ORDER)) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mean_we),
    .waddr_i (i_q[IW-1:0]),
    .wdata_i (mean_new),
    .re_i    (mean_re),
    .raddr_i (i_q[IW-1:0]),
    .rdata_o (mean_rdata)
  );

  ddlm_div #(.NUM_W(DW), .DEN_W(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quo_o   (div_res)
  );

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= 17'd64880;
      beta_q  <= 16'd64880;
      order_q <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STATE_DISC: delta_q <= cfg_data_i;
        CFG_VAR_DISC:   beta_q  <= cfg_data_i[15:0];
        CFG_ORDER:      order_q <= cfg_data_i[3:0];
        default:        ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ec_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cvalid_q    <= '0;
      mvalid_q    <= '0;
      n_q         <= ONE_DW;
      d_q         <= ONE_DW;
      s_q         <= ONE_DW;
      err_q       <= 1'b0;
      div_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_start) begin
        div_wait_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_word_i.series_start) begin
              cvalid_q <= '0;
              mvalid_q <= '0;
              n_q      <= ONE_DW;
              d_q      <= ONE_DW;
              s_q      <= ONE_DW;
            end
            row_q[ec_eff] <= sat_dw(SW'(in_word_i.regressor));
            if (row_done) begin
              ec_q    <= '0;
              y_q     <= sat_dw(SW'(in_word_i.observation));
              i_q     <= '0;
              acc_q   <= '0;
              state_q <= S_F_RD;
            end else begin
              ec_q <= ec_eff + IW'(1);
            end
          end
        end
        S_F_RD: begin
          mvld_q  <= mvalid_q[i_q[IW-1:0]];
          state_q <= S_F_MUL;
        end
        S_F_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_F_ACC;
        end
        S_F_ACC: begin
          if (i_last) begin
            f_q     <= q_new;
            i_q     <= '0;
            j_q     <= '0;
            acc_q   <= '0;
            state_q <= S_A_RD;
          end else begin
            acc_q   <= acc_nx;
            i_q     <= i_nx;
            state_q <= S_F_RD;
          end
        end
        S_A_RD, S_C_RD: begin
          cvld_q  <= cvalid_q[cov_addr];
          cdiag_q <= (i_q == j_q);
          state_q <= (state_q == S_A_RD) ? S_A_DIV : S_C_DIV;
        end
        S_A_DIV: begin
          if (div_wait_q && div_stat.done) begin
            div_wait_q <= 1'b0;
            state_q    <= S_A_MUL;
          end
        end
        S_A_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_A_ACC;
        end
        S_A_ACC: begin
          if (j_last) begin
            av_q[i_q[IW-1:0]] <= q_new;
            j_q <= '0;
            if (i_last) begin
              i_q     <= '0;
              acc_q   <= to_sw(s_q);
              state_q <= S_Q_MUL;
            end else begin
              i_q     <= i_nx;
              acc_q   <= '0;
              state_q <= S_A_RD;
            end
          end else begin
            j_q     <= j_nx;
            acc_q   <= acc_nx;
            state_q <= S_A_RD;
          end
        end
        S_Q_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_Q_ACC;
        end
        S_Q_ACC: begin
          if (i_last) begin
            q_q <= q_new;
            i_q <= '0;
            if (q_new <= 0) begin
              err_q   <= 1'b1;
              state_q <= S_O_RD;
            end else begin
              err_q   <= 1'b0;
              state_q <= S_K_DIV;
            end
          end else begin
            acc_q   <= acc_nx;
            i_q     <= i_nx;
            state_q <= S_Q_MUL;
          end
        end
        S_K_DIV: begin
          if (div_wait_q && div_stat.done) begin
            div_wait_q        <= 1'b0;
            kv_q[i_q[IW-1:0]] <= div_res;
            if (i_last) begin
              i_q     <= '0;
              state_q <= S_E_SET;
            end else begin
              i_q <= i_nx;
            end
          end
        end
        S_E_SET: begin
          e_q     <= sat_dw(to_sw(y_q) - to_sw(f_q));
          mul_q   <= mul_res;
          state_q <= S_N_SET;
        end
        S_N_SET: begin
          nn_q    <= sat_dw(to_sw(mul_q) + ONE_S);
          mul_q   <= mul_res;
          state_q <= S_SEE_MUL;
        end
        S_SEE_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_SEE_DIV;
        end
        S_SEE_DIV: begin
          if (div_wait_q && div_stat.done) begin
            div_wait_q <= 1'b0;
            state_q    <= S_D_MUL;
          end
        end
        S_D_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_D_SET;
        end
        S_D_SET: begin
          dn_q    <= sat_dw(to_sw(mul_q) + to_sw(div_res));
          state_q <= S_S_DIV;
        end
        S_S_DIV: begin
          if (div_wait_q && div_stat.done) begin
            div_wait_q <= 1'b0;
            sn_q       <= div_res;
            state_q    <= S_R_DIV;
          end
        end
        S_R_DIV: begin
          if (div_wait_q && div_stat.done) begin
            div_wait_q <= 1'b0;
            ratio_q    <= div_res;
            i_q        <= '0;
            j_q        <= '0;
            state_q    <= S_C_RD;
          end
        end
        S_C_DIV: begin
          if (div_wait_q && div_stat.done) begin
            div_wait_q <= 1'b0;
            state_q    <= S_C_MUL;
          end
        end
        S_C_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_C_SUB;
        end
        S_C_SUB: begin
          t_q     <= sat_dw(to_sw(div_res) - to_sw(mul_q));
          state_q <= S_C_MUL2;
        end
        S_C_MUL2: begin
          mul_q   <= mul_res;
          state_q <= S_C_WR;
        end
        S_C_WR: begin
          cvalid_q[cov_addr] <= 1'b1;
          if (j_last) begin
            j_q <= '0;
            if (i_last) begin
              i_q     <= '0;
              n_q     <= nn_q;
              d_q     <= dn_q;
              s_q     <= sn_q;
              state_q <= S_O_RD;
            end else begin
              i_q     <= i_nx;
              state_q <= S_C_RD;
            end
          end else begin
            j_q     <= j_nx;
            state_q <= S_C_RD;
          end
        end
        S_O_RD: begin
          mvld_q  <= mvalid_q[i_q[IW-1:0]];
          state_q <= S_O_MUL;
        end
        S_O_MUL: begin
          mul_q   <= mul_res;
          state_q <= S_O_LD;
        end
        S_O_LD: begin
          if (slot_free) begin
            out_q.component_index      <= 3'(i_q);
            out_q.component_mean       <= out_s32(err_q ? mean_rd : mean_new);
            out_q.forecast             <= out_s32(f_q);
            out_q.forecast_variance    <= err_q ? '0 : out_u31(q_q);
            out_q.scale_estimate       <= out_u31(s_q);
            out_q.degrees_freedom      <= out_u31(n_q);
            out_q.numeric_error        <= err_q;
            out_q.last_component       <= i_last;
            if (!err_q) begin
              mvalid_q[i_q[IW-1:0]] <= 1'b1;
            end
            if (i_last) begin
              i_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_nx;
              state_q <= S_O_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_cov_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cov_we |-> !err_q)
    else $error("covariance written on a failed step");

  a_mean_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mean_we |-> (state_q == S_O_LD) && !err_q)
    else $error("mean written outside update");

  a_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_O_LD && slot_free && i_last) |=> !in_stall_o && out_valid_o)
    else $error("step did not close after last word");

endmodule

/* design/ddlm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ddlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ddlm_div.sv */
// Radix-2 restoring Q16.16 divider, round half away from zero, saturating.
// Depends on ddlm_pkg (status struct, FRAC_BITS and width default).
module ddlm_div import ddlm_pkg::*; #(
  parameter int NUM_W = DATA_WIDTH_DEF,
  parameter int DEN_W = DATA_WIDTH_DEF + 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output div_stat_t               stat_o,
  output logic signed [NUM_W-1:0] quo_o
);

  localparam int NW  = NUM_W + FRAC_BITS;
  localparam int CNW = $clog2(NW + 1);
  localparam logic [NW:0] VMAX_Q = (NW+1)'((NW+1)'(1) << (NUM_W - 1)) - (NW+1)'(1);
  localparam logic signed [NUM_W-1:0] VMAX_N = VMAX_Q[NUM_W-1:0];
  localparam logic signed [NUM_W-1:0] VMIN_N = ~VMAX_N;

  logic             busy_q, done_q, neg_q;
  logic [CNW-1:0]   cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NW-1:0]    sh_q;
  logic signed [NUM_W-1:0] res_q;

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [DEN_W:0]   trial;
  logic             fit;
  logic             up;
  logic [NW:0]      qr;

  assign num_mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign den_mag = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
  assign trial   = {rem_q, sh_q[NW-1]};
  assign fit     = trial >= {1'b0, den_q};
  assign up      = {rem_q, 1'b0} >= {1'b0, den_q};
  assign qr      = (NW+1)'(sh_q) + (NW+1)'(up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        neg_q <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
        den_q <= den_mag;
        rem_q <= '0;
        sh_q  <= {num_mag, FRAC_BITS'(0)};
        cnt_q <= CNW'(NW);
        if (den_mag == '0) begin
          res_q  <= num_i[NUM_W-1] ? VMIN_N : VMAX_N;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          done_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          if (neg_q) begin
            res_q <= (qr > VMAX_Q + (NW+1)'(1)) ? VMIN_N : -qr[NUM_W-1:0];
          end else begin
            res_q <= (qr > VMAX_Q) ? VMAX_N : qr[NUM_W-1:0];
          end
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          rem_q  <= fit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
          sh_q   <= {sh_q[NW-2:0], fit};
          cnt_q  <= cnt_q - CNW'(1);
          done_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = res_q;

endmodule
